// File: hw/rtl/kbez_pkg.sv
// shared constants and types for the keyframe bezier evaluator
package kbez_pkg;
    localparam int KbezMaxKeys = 16;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_DUP = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_NO_BRACKET = 3'd4;
    localparam logic [15:0] NOT_BRACKETED = 16'hF000;
    typedef struct packed {
        logic [15:0] t;
        logic [15:0] v;
        logic [15:0] hin;
        logic [15:0] hout;
    } t_key;
endpackage

// File: hw/rtl/keyframe_bezier_curve_eval_core.sv
// top level: key memory, scan sequencer, divider and blend
//
// Command interface: drive i_operation and the payload with i_start while
// o_busy is low; the request is taken at that edge. One result comes back
// on o_status, o_new_index and o_curve_value with o_valid high for one cycle.
// The receiver cannot stall, and the block never holds a result back.
// Keys live in one synchronous memory (one read, one write per cycle, read
// data registered). Add scans all stored keys for a duplicate. Remove copies
// each later key down one slot. Evaluate scans the keys in order and, when
// the query falls between two keys, runs the divide and then the blend. The
// memory port and the one bit a cycle divider set the rate.
// Reset empties the table at once; memory contents need no clearing.
// o_busy stays high from acceptance until the cycle after the result.
module keyframe_bezier_curve_eval_core
    import kbez_pkg::*;
#(
    parameter int MAX_KEYS = KbezMaxKeys
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic signed [15:0] i_time_point,
    input  logic signed [15:0] i_key_value,
    input  logic signed [15:0] i_in_handle_y,
    input  logic signed [15:0] i_out_handle_y,
    input  logic [3:0]  i_key_index,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [3:0]  o_new_index,
    output logic signed [15:0] o_curve_value
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_READE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_BLEND = 3'd5;

    t_key r_mem [MAX_KEYS];
    t_key r_rd;
    logic [AW-1:0] n_raddr;
    logic          n_we;
    logic [AW-1:0] n_waddr;
    t_key          n_wdata;

    logic [2:0]  r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic        r_rdv;
    logic [CW-1:0] r_ridx;
    logic [1:0]  r_op;
    logic [15:0] r_q;
    t_key        r_new;
    logic        r_dup;
    t_key        r_kb;
    logic        r_have_b;
    logic [15:0] r_u;
    logic        r_div_go, r_blend_go;
    logic        div_done, blend_done;
    logic [15:0] div_quo, blend_y;
    logic [16:0] w_num, w_den;
    logic        r_busy;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rd <= r_mem[n_raddr];
    end

    assign w_num = {r_q[15], r_q} - {r_kb.t[15], r_kb.t};
    assign w_den = {r_rd.t[15], r_rd.t} - {r_kb.t[15], r_kb.t};

    kbez_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_div_go),
        .i_num(w_num), .i_den(w_den), .o_done(div_done), .o_quo(div_quo)
    );

    kbez_blend u_blend (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_blend_go), .i_u(r_u),
        .i_p0(r_kb.v), .i_p1(r_kb.hout), .i_p2(r_rd.hin), .i_p3(r_rd.v),
        .o_done(blend_done), .o_y(blend_y)
    );

    assign o_busy = r_busy;

    always_comb begin
        n_raddr = r_idx[AW-1:0];
        n_we    = 1'b0;
        n_waddr = r_idx[AW-1:0];
        n_wdata = r_rd;
        if (r_state == S_MOVE && r_rdv) begin
            n_we    = 1'b1;
            n_waddr = AW'(r_ridx - CW'(1));
        end
        if (r_state == S_SCAN && r_op == OP_ADD && r_rdv && r_ridx == r_count
                && !r_dup && r_count < CW'(MAX_KEYS)) begin
            n_we    = 1'b1;
            n_waddr = r_count[AW-1:0];
            n_wdata = r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
            r_rdv   <= 1'b0;
            r_div_go <= 1'b0;
            r_blend_go <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_div_go <= 1'b0;
            r_blend_go <= 1'b0;
            r_rdv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && !r_busy) begin
                        r_busy <= 1'b1;
                        r_op   <= i_operation;
                        r_q    <= i_time_point;
                        r_new  <= '{t: i_time_point, v: i_key_value,
                                    hin: i_in_handle_y, hout: i_out_handle_y};
                        r_dup  <= 1'b0;
                        r_have_b <= 1'b0;
                        o_status <= ST_OK;
                        o_new_index <= '0;
                        o_curve_value <= '0;
                        if (i_operation == OP_REMOVE) begin
                            if (CW'(i_key_index) >= r_count
                                    || 32'(i_key_index) >= MAX_KEYS) begin
                                o_status <= ST_BAD_INDEX;
                                o_valid  <= 1'b1;
                            end else begin
                                r_idx <= CW'(i_key_index) + CW'(1);
                                r_state <= S_MOVE;
                            end
                        end else if (i_operation == OP_ADD
                                || i_operation == OP_EVAL) begin
                            r_idx <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            o_valid <= 1'b1;
                        end
                    end else begin
                        r_busy <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // issue reads one per cycle; examine the data in the next cycle
                    if (r_idx < r_count) begin
                        r_rdv  <= 1'b1;
                        r_ridx <= r_idx;
                        r_idx  <= r_idx + CW'(1);
                    end else if (!r_rdv) begin
                        r_rdv  <= 1'b1;
                        r_ridx <= r_count;
                    end
                    if (r_rdv) begin
                        if (r_ridx == r_count) begin
                            r_state <= S_IDLE;
                            o_valid <= 1'b1;
                            r_rdv   <= 1'b0;
                            if (r_op == OP_ADD) begin
                                if (r_dup) o_status <= ST_DUP;
                                else if (r_count >= CW'(MAX_KEYS))
                                    o_status <= ST_FULL;
                                else begin
                                    o_new_index <= 4'(r_count);
                                    r_count <= r_count + CW'(1);
                                end
                            end else begin
                                o_status <= ST_NO_BRACKET;
                                o_curve_value <= NOT_BRACKETED;
                            end
                        end else if (r_op == OP_ADD) begin
                            if (r_rd.t == r_q) r_dup <= 1'b1;
                        end else if (r_rd.t == r_q) begin
                            o_curve_value <= r_rd.v;
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                            r_rdv   <= 1'b0;
                        end else if ($signed(r_rd.t) < $signed(r_q)) begin
                            r_have_b <= 1'b1;
                            r_kb <= r_rd;
                        end else begin
                            r_rdv <= 1'b0;
                            if (!r_have_b) begin
                                o_status <= ST_NO_BRACKET;
                                o_curve_value <= NOT_BRACKETED;
                                o_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_idx <= r_ridx;
                                r_state <= S_READE;
                            end
                        end
                    end
                end
                S_READE: begin
                    // r_idx re-addresses the end key so that its data is in r_rd when the divide starts
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_u <= div_quo;
                        r_blend_go <= 1'b1;
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    if (blend_done) begin
                        o_curve_value <= blend_y;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_MOVE: begin
                    if (r_rdv) begin
                        r_idx <= r_ridx + CW'(1);
                    end else if (r_idx < r_count) begin
                        r_rdv  <= 1'b1;
                        r_ridx <= r_idx;
                    end else begin
                        r_count <= r_count - CW'(1);
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS))
        else $error("key count beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result without a request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results for one request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND) |-> r_have_b)
        else $error("blend without a begin key");
endmodule

// File: hw/rtl/kbez_div.sv
// restoring divider giving the 16 bit segment fraction, one bit a cycle
module kbez_div
    import kbez_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [16:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [15:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    logic [17:0] w_sub;

    assign w_sh  = {r_rem[16:0], 1'b0};
    assign w_sub = w_sh - {1'b0, r_den};
    assign o_quo = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                if (!w_sub[17]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: hw/rtl/kbez_blend.sv
// sequential bezier blend: weights and weighted sum, each weight added in as the next is formed
module kbez_blend
    import kbez_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [15:0] i_u,
    input  logic [15:0] i_p0,
    input  logic [15:0] i_p1,
    input  logic [15:0] i_p2,
    input  logic [15:0] i_p3,
    output logic        o_done,
    output logic [15:0] o_y
);
    // step sequence on one shared 17x34 multiplier, plus a 51x16 signed weight-by-point multiplier
    logic [3:0]  r_step;
    logic        r_busy;
    logic [16:0] r_s;
    logic [16:0] r_u;
    logic [33:0] r_ss, r_su, r_uu;
    logic [50:0] r_w;
    logic signed [67:0] r_acc;
    logic [15:0] r_p [4];
    logic [16:0] w_a;
    logic [33:0] w_b;
    logic [50:0] w_prod;
    logic signed [67:0] w_term;
    logic [67:0] w_rnd;

    assign w_prod = 51'(w_a) * 51'(w_b);
    assign w_term = $signed({17'd0, r_w}) * $signed({{52{r_p[r_step[1:0]][15]}},
                    r_p[r_step[1:0]]});
    assign w_rnd = r_acc + 68'sh8000_0000_0000;
    assign o_y = w_rnd[63:48];

    always_comb begin
        w_a = r_s;
        w_b = {17'd0, r_s};
        case (r_step)
            4'd0: begin w_a = r_s; w_b = {17'd0, r_s}; end
            4'd1: begin w_a = r_s; w_b = {17'd0, r_u}; end
            4'd2: begin w_a = r_u; w_b = {17'd0, r_u}; end
            4'd3: begin w_a = r_s; w_b = r_ss; end
            4'd4: begin w_a = r_s; w_b = r_su; end
            4'd5: begin w_a = r_s; w_b = r_uu; end
            4'd6: begin w_a = r_u; w_b = r_uu; end
            default: begin w_a = r_s; w_b = r_ss; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_u    <= {1'b0, i_u};
                r_s    <= 17'h10000 - {1'b0, i_u};
                r_p[0] <= i_p0;
                r_p[1] <= i_p1;
                r_p[2] <= i_p2;
                r_p[3] <= i_p3;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                case (r_step)
                    4'd0: r_ss <= w_prod[33:0];
                    4'd1: r_su <= w_prod[33:0];
                    4'd2: r_uu <= w_prod[33:0];
                    4'd3: r_w <= w_prod;
                    4'd4: r_w <= w_prod;
                    4'd5: r_w <= w_prod;
                    4'd6: r_w <= w_prod;
                    default: ;
                endcase
                // weight for point k is applied the cycle after it is formed
                case (r_step)
                    4'd4: r_acc <= r_acc + w_term;
                    4'd5: r_acc <= r_acc + 68'sd3 * w_term;
                    4'd6: r_acc <= r_acc + 68'sd3 * w_term;
                    4'd7: begin
                        r_acc  <= r_acc + w_term;
                        r_busy <= 1'b0;
                    end
                    default: ;
                endcase
                if (r_step == 4'd8) r_busy <= 1'b0;
            end
            if (r_busy && r_step == 4'd7) o_done <= 1'b1;
        end
    end
endmodule

// File: tb/sv/keyframe_bezier_curve_eval_checker.sv
// checker for the keyframe bezier evaluator: key table predictor and result compare
`timescale 1ns / 1ps
module keyframe_bezier_curve_eval_checker
    import kbez_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_operation,
    input  logic signed [15:0] i_time_point,
    input  logic signed [15:0] i_key_value,
    input  logic signed [15:0] i_in_handle_y,
    input  logic signed [15:0] i_out_handle_y,
    input  logic [3:0]  i_key_index,
    input  logic        i_valid,
    input  logic [2:0]  i_status,
    input  logic [3:0]  i_new_index,
    input  logic signed [15:0] i_curve_value,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_curve_count
);
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  new_index;
        logic [15:0] curve;
    } t_answer;

    t_key      keys[KbezMaxKeys];
    int        n_keys;
    t_answer   answers[$];

    function automatic logic [15:0] blend_height(t_key kb, t_key ke, logic signed [15:0] q);
        longint num, den, u, s, acc;
        logic [63:0] ua;
        num = longint'(q) - longint'($signed(kb.t));
        den = longint'($signed(ke.t)) - longint'($signed(kb.t));
        u = (num <<< 16) / den;
        s = 65536 - u;
        acc = s * s * s * longint'($signed(kb.v));
        acc += 3 * s * s * u * longint'($signed(kb.hout));
        acc += 3 * s * u * u * longint'($signed(ke.hin));
        acc += u * u * u * longint'($signed(ke.v));
        ua = 64'(acc) ^ 64'h8000_0000_0000_0000;
        ua = ((ua + 64'h8000_0000_0000) >> 48) - 64'd32768;
        return ua[15:0];
    endfunction

    function automatic t_answer apply_request(logic [1:0] op, logic signed [15:0] tp,
            logic [15:0] kv, logic [15:0] hi, logic [15:0] ho, logic [3:0] idx);
        t_answer a;
        bit dup, hit, have_b, have_e;
        int b, e;
        a = '0;
        if (op == OP_ADD) begin
            dup = 0;
            for (int i = 0; i < n_keys; i++) if (keys[i].t == tp) dup = 1;
            if (dup) a.status = ST_DUP;
            else if (n_keys >= KbezMaxKeys) a.status = ST_FULL;
            else begin
                keys[n_keys] = '{t: tp, v: kv, hin: hi, hout: ho};
                a.new_index = 4'(n_keys);
                n_keys++;
            end
        end else if (op == OP_REMOVE) begin
            if (int'(idx) >= n_keys) a.status = ST_BAD_INDEX;
            else begin
                for (int i = int'(idx); i + 1 < n_keys; i++) keys[i] = keys[i + 1];
                n_keys--;
            end
        end else if (op == OP_EVAL) begin
            hit = 0; have_b = 0; have_e = 0; b = 0; e = 0;
            for (int i = 0; i < n_keys; i++) begin
                if ($signed(keys[i].t) == tp) begin
                    hit = 1;
                    a.curve = keys[i].v;
                    break;
                end
                if ($signed(keys[i].t) < tp) begin
                    have_b = 1;
                    b = i;
                end else begin
                    have_e = 1;
                    e = i;
                    break;
                end
            end
            if (!hit) begin
                if (!have_b || !have_e) begin
                    a.status = ST_NO_BRACKET;
                    a.curve = NOT_BRACKETED;
                end else a.curve = blend_height(keys[b], keys[e], tp);
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer got, exp_a, nxt;
        if (!i_rst_n) begin
            n_keys = 0;
            answers.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_curve_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                got = '{status: i_status, new_index: i_new_index, curve: i_curve_value};
                o_result_count <= o_result_count + 1;
                if (answers.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_a = answers.pop_front();
                    if (exp_a.status == ST_OK && exp_a.curve != 0) o_curve_count <= o_curve_count + 1;
                    if (got !== exp_a) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch status %0d/%0d index %0d/%0d value %h/%h",
                                $time, exp_a.status, got.status, exp_a.new_index,
                                got.new_index, exp_a.curve, got.curve);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                nxt = apply_request(i_operation, i_time_point, i_key_value,
                    i_in_handle_y, i_out_handle_y, i_key_index);
                answers = {answers, nxt};
            end
            o_pending <= answers.size();
        end
    end
endmodule

// File: tb/sv/keyframe_bezier_curve_eval_core_tb.sv
// testbench top for the keyframe bezier evaluator: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module keyframe_bezier_curve_eval_core_tb;
    import kbez_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        o_busy;
    logic [1:0]  i_operation = OP_EVAL;
    logic signed [15:0] i_time_point = 0, i_key_value = 0, i_in_handle_y = 0, i_out_handle_y = 0;
    logic [3:0]  i_key_index = 0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_new_index;
    logic signed [15:0] o_curve_value;
    int fail_count, pending, result_count, curve_count;
    int n_requests;
    logic signed [15:0] recent_times[$];

    always #4 i_clk = ~i_clk;

    keyframe_bezier_curve_eval_core i_dut (.*);

    keyframe_bezier_curve_eval_checker i_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_operation, .i_time_point,
        .i_key_value, .i_in_handle_y, .i_out_handle_y, .i_key_index,
        .i_valid(o_valid), .i_status(o_status), .i_new_index(o_new_index),
        .i_curve_value(o_curve_value), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_curve_count(curve_count)
    );

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(logic [1:0] op, logic signed [15:0] tp, logic signed [15:0] kv,
            logic signed [15:0] hi, logic signed [15:0] ho, logic [3:0] idx, bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_time_point <= tp;
        i_key_value <= kv;
        i_in_handle_y <= hi;
        i_out_handle_y <= ho;
        i_key_index <= idx;
        i_start <= 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_ADD) recent_times = {recent_times, tp};
        if (recent_times.size() > 24) void'(recent_times.pop_front());
        n_requests++;
    endtask

    task automatic random_request(bit allow_gap);
        logic signed [15:0] tp;
        int r;
        r = $urandom_range(0, 99);
        if (recent_times.size() > 0 && $urandom_range(0, 5) == 0)
            tp = recent_times[$urandom_range(0, recent_times.size() - 1)];
        else if ($urandom_range(0, 3) == 0) tp = 16'($urandom);
        else tp = 16'($urandom_range(0, 2000)) - 16'sd1000;
        if (r < 35)
            send_request(OP_ADD, tp, pick_value(), pick_value(), pick_value(), 4'($urandom), allow_gap);
        else if (r < 50)
            send_request(OP_REMOVE, tp, pick_value(), pick_value(), pick_value(),
                4'($urandom), allow_gap);
        else if (r < 97)
            send_request(OP_EVAL, tp, pick_value(), pick_value(), pick_value(), 4'($urandom), allow_gap);
        else
            send_request(OP_NONE, tp, pick_value(), pick_value(), pick_value(), 4'($urandom), allow_gap);
    endtask

    initial begin
        #10_000_000;
        $display("** keyframe_bezier_curve_eval_core: FAILED **");
        $finish;
    end

    initial begin
        n_requests = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: empty table, extremes, full table, bad index, unused op
        send_request(OP_EVAL, 0, 0, 0, 0, 0, 0);
        send_request(OP_REMOVE, 0, 0, 0, 0, 0, 0);
        send_request(OP_ADD, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 0, 0);
        send_request(OP_ADD, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 4'hF, 0);
        send_request(OP_EVAL, 0, 0, 0, 0, 0, 0);
        send_request(OP_EVAL, -16'sh7FFF, 0, 0, 0, 0, 0);
        send_request(OP_EVAL, 16'sh7FFE, 0, 0, 0, 0, 0);
        send_request(OP_EVAL, 16'sh7FFF, 0, 0, 0, 0, 0);
        send_request(OP_ADD, 16'sh7FFF, 1, 1, 1, 0, 0);
        for (int i = 0; i < 14; i++)
            send_request(OP_ADD, 16'(i * 100), pick_value(), pick_value(), pick_value(), 0, 0);
        send_request(OP_ADD, 16'sh1234, 0, 0, 0, 0, 0);
        send_request(OP_REMOVE, 0, 0, 0, 0, 4'hF, 0);
        send_request(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 0);
        send_request(OP_REMOVE, 0, 0, 0, 0, 4'hF, 0);
        send_request(OP_EVAL, 16'sh0032, 0, 0, 0, 0, 0);
        for (int i = 0; i < 1750; i++) begin
            random_request(i < 1500);
            // drain the table now and then to cycle through empty and full states
            if (i % 300 == 299)
                for (int j = 0; j < 16; j++) send_request(OP_REMOVE, 0, 0, 0, 0, 0, 0);
        end
        i_start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("ran %0d requests, checked %0d results, %0d of them nonzero curve values",
            n_requests, result_count, curve_count);
        if (fail_count == 0)
            $display("** keyframe_bezier_curve_eval_core: PASSED **");
        else
            $display("** keyframe_bezier_curve_eval_core: FAILED **");
        $finish;
    end
endmodule
